// ----- rtl/segsum_pkg.sv -----
// Shared widths, defaults and operation codes for the segment tree range-sum block.
`timescale 1ns / 1ps

package segsum_pkg;

  // Fixed widths of the item fields.
  localparam int IDX_W = 10;
  localparam int VAL_W = 16;
  localparam int SUM_W = 26;

  // Default number of elements held in the tree.
  localparam int DEFAULT_ELEMENT_COUNT = 1024;

  // Operation codes carried by the operation field.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

// ----- rtl/segment_tree_range_sum.sv -----
// Segment tree over signed 16-bit elements: point update and inclusive range sum.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+-----------------------------------------
// command   | in        | start high, busy low  | operation, element_index, new_value,
//           |           |                       | range_low, range_high
// result    | out       | done, one cycle       | range_sum, bad_request
//
// An update reads its leaf, writes the new value there and then climbs log2(P) levels to
// the root, adding the difference to each node on the path; a query visits up to
// log2(P) + 1 levels and then adds in the last node reads. P is ELEMENT_COUNT rounded up
// to a power of two. The walk through the tree memory takes one tree level per cycle.
// Reset starts a clearing pass that writes zero to all 2P tree entries, one per cycle, and
// busy stays high until it finishes.
// Ignored updates and reversed or empty queries give their result in the next cycle.
// The receiver cannot stall: each result is shown for exactly one cycle with done high.

module segment_tree_range_sum
  import segsum_pkg::*;
#(
  parameter int ELEMENT_COUNT = DEFAULT_ELEMENT_COUNT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    operation,
  input  logic [IDX_W-1:0]        element_index,
  input  logic signed [VAL_W-1:0] new_value,
  input  logic [IDX_W-1:0]        range_low,
  input  logic [IDX_W-1:0]        range_high,
  output logic                    done,
  output logic signed [SUM_W-1:0] range_sum,
  output logic                    bad_request
);

  // The tree is stored heap style: node 1 is the root, nodes P to 2P-1 are the leaves,
  // and leaf P + i holds element i. Leaves past the element count stay zero.
  localparam int LOG_P  = (ELEMENT_COUNT > 2) ? $clog2(ELEMENT_COUNT) : 1;
  localparam int ADDR_W = LOG_P + 1;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int PTR_W  = LOG_P + 2;
  // A node sum is bounded by P elements of 16 bits.
  localparam int NODE_W = VAL_W + LOG_P;
  localparam int CMP_W  = (IDX_W > LOG_P + 1) ? IDX_W + 1 : LOG_P + 2;
  localparam int EXT_W  = (NODE_W > SUM_W) ? NODE_W : SUM_W;

  localparam logic [CMP_W-1:0] COUNT    = CMP_W'(ELEMENT_COUNT);
  localparam logic [CMP_W-1:0] COUNT_M1 = CMP_W'(ELEMENT_COUNT - 1);
  localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(-(64'sd1 <<< (SUM_W - 1)));

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ULEAF = 3'd2;
  localparam logic [2:0] ST_UPATH = 3'd3;
  localparam logic [2:0] ST_QWALK = 3'd4;

  logic [2:0] state;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] node;
  logic signed [NODE_W-1:0] diff;
  logic signed [VAL_W-1:0] new_val;
  logic [PTR_W-1:0] l;
  logic [PTR_W-1:0] r;
  logic signed [NODE_W-1:0] acc;
  logic pend_a;
  logic pend_b;

  // Tree memory: one write port and two registered read ports.
  logic signed [NODE_W-1:0] mem [DEPTH];
  logic wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic signed [NODE_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_a_addr;
  logic [ADDR_W-1:0] rd_b_addr;
  logic signed [NODE_W-1:0] rd_a_data;
  logic signed [NODE_W-1:0] rd_b_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

  // Decoding of the incoming item.
  logic accept;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] lo_ext;
  logic [CMP_W-1:0] hi_ext;
  logic [CMP_W-1:0] hi_clamp;
  logic idx_ok;
  logic qry_bad;
  logic qry_empty;
  logic [ADDR_W-1:0] leaf;
  logic [PTR_W-1:0] l_start;
  logic [PTR_W-1:0] r_start;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    idx_ext   = CMP_W'(element_index);
    lo_ext    = CMP_W'(range_low);
    hi_ext    = CMP_W'(range_high);
    hi_clamp  = (hi_ext > COUNT_M1) ? COUNT_M1 : hi_ext;
    idx_ok    = idx_ext < COUNT;
    qry_bad   = lo_ext > hi_ext;
    qry_empty = lo_ext > hi_clamp;
    leaf      = {1'b1, idx_ext[LOG_P-1:0]};
    l_start   = {2'b01, lo_ext[LOG_P-1:0]};
    r_start   = PTR_W'({1'b1, hi_clamp[LOG_P-1:0]}) + PTR_W'(1);
  end

  // Query walk: l and r bound a half-open span of nodes on one level. An odd left end
  // and an odd right end each take one node into the sum before both climb a level.
  logic take_l;
  logic take_r;
  logic [PTR_W-1:0] r_m1;
  logic [PTR_W-1:0] l_next;
  logic [PTR_W-1:0] r_next;
  logic signed [NODE_W-1:0] sum_fin;
  logic signed [EXT_W-1:0] sum_ext;
  logic signed [SUM_W-1:0] sum_sat;

  always_comb begin
    take_l  = l[0];
    take_r  = r[0];
    r_m1    = r - PTR_W'(1);
    l_next  = (l + PTR_W'(take_l)) >> 1;
    r_next  = (r - PTR_W'(take_r)) >> 1;
    sum_fin = acc + (pend_a ? rd_a_data : '0) + (pend_b ? rd_b_data : '0);
    sum_ext = EXT_W'(sum_fin);
    if (sum_ext > SAT_HI) begin
      sum_sat = SAT_HI[SUM_W-1:0];
    end else if (sum_ext < SAT_LO) begin
      sum_sat = SAT_LO[SUM_W-1:0];
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  // Memory port control.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = node;
    wr_data   = rd_a_data + diff;
    rd_a_addr = {1'b0, node[ADDR_W-1:1]};
    rd_b_addr = r_m1[ADDR_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      ST_IDLE: begin
        rd_a_addr = leaf;
      end
      ST_ULEAF: begin
        // The leaf holds the element itself; the difference climbs the path.
        wr_en   = 1'b1;
        wr_data = NODE_W'(new_val);
      end
      ST_UPATH: begin
        wr_en = 1'b1;
      end
      ST_QWALK: begin
        rd_a_addr = l[ADDR_W-1:0];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      pend_a   <= 1'b0;
      pend_b   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            range_sum   <= '0;
            bad_request <= 1'b0;
            if (operation == OP_UPDATE) begin
              if (idx_ok) begin
                node    <= leaf;
                new_val <= new_value;
                state   <= ST_ULEAF;
              end else begin
                done <= 1'b1;
              end
            end else if (qry_bad) begin
              bad_request <= 1'b1;
              done        <= 1'b1;
            end else if (qry_empty) begin
              done <= 1'b1;
            end else begin
              l      <= l_start;
              r      <= r_start;
              acc    <= '0;
              pend_a <= 1'b0;
              pend_b <= 1'b0;
              state  <= ST_QWALK;
            end
          end
        end
        ST_ULEAF: begin
          diff  <= NODE_W'(new_val) - rd_a_data;
          node  <= {1'b0, node[ADDR_W-1:1]};
          state <= ST_UPATH;
        end
        ST_UPATH: begin
          if (node == ADDR_W'(1)) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            node <= {1'b0, node[ADDR_W-1:1]};
          end
        end
        ST_QWALK: begin
          acc <= sum_fin;
          if (l < r) begin
            pend_a <= take_l;
            pend_b <= take_r;
            l      <= l_next;
            r      <= r_next;
          end else begin
            pend_a    <= 1'b0;
            pend_b    <= 1'b0;
            range_sum <= sum_sat;
            done      <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result only ever follows an accepted item or the end of a walk.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept) || $past(state == ST_UPATH) || $past(state == ST_QWALK))
    else $error("result strobe without an item in progress");

  // A flagged query carries a zero sum.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && bad_request |-> range_sum == '0)
    else $error("bad request with non-zero sum");

  // The query span never turns over on itself.
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_QWALK |-> l <= r)
    else $error("query walk span inverted");

  // Outside the clearing pass, writes go only to tree nodes, never to unused entry zero.
  a_no_node_zero: assert property (@(posedge clk) disable iff (rst)
    wr_en && state != ST_CLEAR |-> wr_addr != '0)
    else $error("write to unused node zero");

  // An update walk writes a node and reads its parent in the same cycle.
  a_upath_parent: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPATH |-> rd_a_addr == {1'b0, wr_addr[ADDR_W-1:1]})
    else $error("update walk lost the parent address");

endmodule
